[rtl/kgr_pkg.sv]
// Shared types and constants for the k-group reverser.
package kgr_pkg;

	localparam int VALUE_W = 32;
	localparam int GS_W    = 5;

	// Per-cycle move of the cell chain
	typedef enum logic [1:0] {
		SHIFT_HOLD,
		SHIFT_PUSH,
		SHIFT_POP
	} shift_op_t;

	// Control handed to every cell
	typedef struct packed {
		shift_op_t op;
	} cell_ctrl_t;

	typedef enum logic {
		ST_COLLECT,
		ST_EMIT
	} state_t;

endpackage

[rtl/kgr_if.sv]
// Channel interfaces: input items, result items and the group size write port.
interface kgr_in_if;
	logic                               valid;
	logic                               ready;
	logic signed [kgr_pkg::VALUE_W-1:0] value;
	logic                               end_of_sequence;

	modport source (output valid, output value, output end_of_sequence, input ready);
	modport sink   (input valid, input value, input end_of_sequence, output ready);
endinterface

interface kgr_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [kgr_pkg::VALUE_W-1:0] value_out;
	logic                               last_of_run;
	logic                               sequence_done;

	modport source (output valid, output value_out, output last_of_run,
		output sequence_done, input ready);
	modport sink   (input valid, input value_out, input last_of_run,
		input sequence_done, output ready);
endinterface

interface kgr_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [kgr_pkg::GS_W-1:0]      data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[rtl/kgr_cell.sv]
// One storage cell of the group chain: holds a value, shifts right on push, left on pop.
module kgr_cell (
	input  logic                               clk,
	input  kgr_pkg::cell_ctrl_t                ctrl,
	input  logic signed [kgr_pkg::VALUE_W-1:0] from_left,
	input  logic signed [kgr_pkg::VALUE_W-1:0] from_right,
	output logic signed [kgr_pkg::VALUE_W-1:0] data_q
);

	// payload only, no reset needed
	always_ff @(posedge clk) begin
		case (ctrl.op)
			kgr_pkg::SHIFT_PUSH: data_q <= from_left;
			kgr_pkg::SHIFT_POP:  data_q <= from_right;
			default:             data_q <= data_q;
		endcase
	end

endmodule

[rtl/kgr_group_reverser_top.sv]
// Holds no module; the k-group reverser top level is defined in k_group_reverser_top.sv.

[rtl/k_group_reverser_top.sv]
// A group's results leave through the output register once the transfer that completes
// the group has moved the sequencer to its emit state; the cell chain gives one result
// per cycle while the result side is ready, and pass-through items collect and emit in turn.
// Input is held off while a group drains; the output register lets the next
// input transfer while the final result still waits.
// Reset (arst_n low): group size 0, chain empty, no result pending; cell data is not reset.
module k_group_reverser_top #(
	parameter int MAX_GROUP = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	kgr_cfg_if.sink    cfg,
	kgr_in_if.sink     item,
	kgr_out_if.source  result
);

	localparam int CW = $clog2(MAX_GROUP + 1);
	localparam int IW = $clog2(MAX_GROUP);
	localparam int KW = (CW > kgr_pkg::GS_W) ? CW : kgr_pkg::GS_W;

	logic [kgr_pkg::GS_W-1:0] group_size_q;
	kgr_pkg::state_t          state_q, state_d;
	logic [CW-1:0]            fill_q, fill_d;
	logic [CW-1:0]            rem_q, rem_d;
	logic                     rev_q, rev_d;
	logic                     eos_q, eos_d;

	logic                     out_valid_q;
	logic signed [kgr_pkg::VALUE_W-1:0] out_value_q;
	logic                     out_last_q;
	logic                     out_done_q;

	kgr_pkg::cell_ctrl_t      cell_ctrl;
	logic signed [kgr_pkg::VALUE_W-1:0] cell_val [MAX_GROUP];

	logic                     in_xfer;
	logic                     out_load;
	logic [KW-1:0]            gs_ext;
	logic [KW-1:0]            k_eff;
	logic [CW-1:0]            n_next;
	logic                     group_full;
	logic [IW-1:0]            rd_idx;
	logic signed [kgr_pkg::VALUE_W-1:0] emit_value;

	// group size register
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_size_q <= '0;
		end else if (cfg.valid) begin
			group_size_q <= cfg.data;
		end
	end

	// effective group size: below 2 is one, above MAX_GROUP clamps
	assign gs_ext = KW'(group_size_q);
	always_comb begin
		if (group_size_q < kgr_pkg::GS_W'(2)) begin
			k_eff = KW'(1);
		end else if (gs_ext > KW'(MAX_GROUP)) begin
			k_eff = KW'(MAX_GROUP);
		end else begin
			k_eff = gs_ext;
		end
	end

	assign n_next     = fill_q + CW'(1);
	assign group_full = KW'(n_next) >= k_eff;

	assign item.ready = (state_q == kgr_pkg::ST_COLLECT);
	assign in_xfer    = item.valid && item.ready;
	assign out_load   = !out_valid_q || result.ready;

	// value to emit: newest-first pops cell 0, oldest-first reads the tail
	assign rd_idx     = IW'(rem_q - CW'(1));
	assign emit_value = rev_q ? cell_val[0] : cell_val[rd_idx];

	// sequencer next state and chain control
	always_comb begin
		state_d      = state_q;
		fill_d       = fill_q;
		rem_d        = rem_q;
		rev_d        = rev_q;
		eos_d        = eos_q;
		cell_ctrl.op = kgr_pkg::SHIFT_HOLD;
		unique case (state_q)
			kgr_pkg::ST_COLLECT: begin
				if (in_xfer) begin
					cell_ctrl.op = kgr_pkg::SHIFT_PUSH;
					if (group_full || item.end_of_sequence) begin
						state_d = kgr_pkg::ST_EMIT;
						rem_d   = n_next;
						rev_d   = group_full;
						eos_d   = item.end_of_sequence;
						fill_d  = '0;
					end else begin
						fill_d  = n_next;
					end
				end
			end
			kgr_pkg::ST_EMIT: begin
				if (out_load) begin
					if (rev_q) begin
						cell_ctrl.op = kgr_pkg::SHIFT_POP;
					end
					rem_d = rem_q - CW'(1);
					if (rem_q == CW'(1)) begin
						state_d = kgr_pkg::ST_COLLECT;
					end
				end
			end
			default: begin
				state_d = kgr_pkg::ST_COLLECT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kgr_pkg::ST_COLLECT;
			fill_q  <= '0;
			rem_q   <= '0;
			rev_q   <= 1'b0;
			eos_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			rem_q   <= rem_d;
			rev_q   <= rev_d;
			eos_q   <= eos_d;
		end
	end

	// chain of cells: cell 0 takes the new value, the far end pops in zero
	for (genvar i = 0; i < MAX_GROUP; i++) begin : g_cell
		logic signed [kgr_pkg::VALUE_W-1:0] left_val;
		logic signed [kgr_pkg::VALUE_W-1:0] right_val;
		if (i == 0) begin : g_head
			assign left_val = item.value;
		end else begin : g_mid
			assign left_val = cell_val[i-1];
		end
		if (i == MAX_GROUP - 1) begin : g_tail
			assign right_val = '0;
		end else begin : g_inner
			assign right_val = cell_val[i+1];
		end
		kgr_cell u_cell (
			.clk        (clk),
			.ctrl       (cell_ctrl),
			.from_left  (left_val),
			.from_right (right_val),
			.data_q     (cell_val[i])
		);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= (state_q == kgr_pkg::ST_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && state_q == kgr_pkg::ST_EMIT) begin
			out_value_q <= emit_value;
			out_last_q  <= (rem_q == CW'(1));
			out_done_q  <= (rem_q == CW'(1)) && eos_q;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.value_out     = out_value_q;
	assign result.last_of_run   = out_last_q;
	assign result.sequence_done = out_done_q;

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// Testbench for the k-group reverser: directed table plus random sequences, scoreboard check.
module tb;

	localparam int MAX_GROUP    = 16;
	localparam int DRAIN_CYCLES = 20;
	localparam int END_CYCLES   = 30;
	localparam int HOLD_CYCLES  = 150;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int NUM_PHASES   = 12;

	typedef logic signed [kgr_pkg::VALUE_W-1:0] value_t;

	typedef struct packed {
		value_t value_out;
		logic   last_of_run;
		logic   sequence_done;
	} reordered_t;

	typedef struct {
		bit             set_size;
		logic [kgr_pkg::GS_W-1:0] size;
		value_t         value;
		bit             eos;
		bit             typed;
		value_t         exp_value;
		bit             exp_done;
	} stim_row_t;

	logic clk;
	logic arst_n;

	kgr_cfg_if cfg_bus();
	kgr_in_if  item_bus();
	kgr_out_if result_bus();

	k_group_reverser_top #(
		.MAX_GROUP(MAX_GROUP)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_bus),
		.item  (item_bus),
		.result(result_bus)
	);

	// Predictor state
	logic [kgr_pkg::GS_W-1:0] group_size_q;
	value_t          held_vals [MAX_GROUP];
	int              held_count;

	reordered_t  fresh_results[$];
	reordered_t  pending_results[$];
	stim_row_t   dir_rows[$];

	int  mismatch_count;
	int  cycle_count;
	bit  send_burst;
	bit  hold_req;

	// Clock
	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// Timeout
	initial begin
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("status: fail");
		$finish;
	end

	// Reordering predictor: appends the results of one accepted value to fresh_results
	function automatic void reorder_values(input value_t v, input logic eos);
		int unsigned k;
		int unsigned n;
		reordered_t  r;
		if (group_size_q < 2)
			k = 1;
		else if (group_size_q > MAX_GROUP)
			k = MAX_GROUP;
		else
			k = group_size_q;
		if (held_count >= MAX_GROUP)
			held_count = MAX_GROUP - 1;
		held_vals[held_count] = v;
		held_count++;
		n = held_count;
		if (n >= k) begin
			// full group comes out reversed
			for (int i = 0; i < n; i++) begin
				r.value_out     = held_vals[n - 1 - i];
				r.last_of_run   = (i == n - 1);
				r.sequence_done = (i == n - 1) && eos;
				fresh_results.push_back(r);
			end
			held_count = 0;
		end else if (eos) begin
			// partial tail keeps its order
			for (int i = 0; i < n; i++) begin
				r.value_out     = held_vals[i];
				r.last_of_run   = (i == n - 1);
				r.sequence_done = (i == n - 1);
				fresh_results.push_back(r);
			end
			held_count = 0;
		end
	endfunction

	function automatic value_t pick_value();
		case ($urandom_range(0, 7))
			0: return 32'sh80000000;
			1: return 32'sh7FFFFFFF;
			2: return -32'sd1;
			3: return 32'sd0;
			default: return value_t'($urandom());
		endcase
	endfunction

	function automatic void note_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch: %s", msg);
	endfunction

	task automatic add_row(input bit set_size, input logic [kgr_pkg::GS_W-1:0] size,
		input value_t v, input bit eos, input bit typed = 0, input value_t exp_value = 0,
		input bit exp_done = 0);
		stim_row_t row;
		row.set_size  = set_size;
		row.size      = size;
		row.value     = v;
		row.eos       = eos;
		row.typed     = typed;
		row.exp_value = exp_value;
		row.exp_done  = exp_done;
		dir_rows.push_back(row);
	endtask

	// Offer one item, return at the edge where it transfers
	task automatic offer(input value_t v, input logic eos);
		int gap;
		gap = send_burst ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			item_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_bus.valid           <= 1'b1;
		item_bus.value           <= v;
		item_bus.end_of_sequence <= eos;
		do @(posedge clk); while (item_bus.ready !== 1'b1);
	endtask

	// Group size write, only once the block has drained
	task automatic write_size(input logic [kgr_pkg::GS_W-1:0] size);
		item_bus.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.data  <= size;
		do @(posedge clk); while (cfg_bus.ready !== 1'b1);
		cfg_bus.valid <= 1'b0;
		group_size_q = size;
	endtask

	task automatic send_and_predict(input value_t v, input logic eos);
		offer(v, eos);
		fresh_results.delete();
		reorder_values(v, eos);
		foreach (fresh_results[i]) pending_results.push_back(fresh_results[i]);
	endtask

	// Result side: random ready gaps, bursts, and one long hold-off
	initial begin
		int  gap;
		int  seen;
		bit  take_burst;
		bit  hold_done;
		seen       = 0;
		take_burst = 0;
		hold_done  = 0;
		result_bus.ready <= 1'b0;
		forever begin
			if (hold_req && !hold_done) begin
				result_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1;
			end
			if (seen % 24 == 0)
				take_burst = ($urandom_range(0, 3) == 0);
			gap = take_burst ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				result_bus.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_bus.ready <= 1'b1;
			do @(posedge clk); while (result_bus.valid !== 1'b1);
			seen++;
		end
	end

	// Scoreboard: compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		reordered_t want;
		if (arst_n && result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				note_mismatch($sformatf("unexpected result value %0d last %0b done %0b",
					result_bus.value_out, result_bus.last_of_run, result_bus.sequence_done));
			end else begin
				want = pending_results.pop_front();
				if (result_bus.value_out !== want.value_out
						|| result_bus.last_of_run !== want.last_of_run
						|| result_bus.sequence_done !== want.sequence_done)
					note_mismatch($sformatf(
						"expected value %0d last %0b done %0b, got value %0d last %0b done %0b",
						want.value_out, want.last_of_run, want.sequence_done,
						result_bus.value_out, result_bus.last_of_run,
						result_bus.sequence_done));
			end
		end
	end

	// Stimulus
	initial begin
		int         phase_sizes [NUM_PHASES];
		int         k_eff;
		int         seq_len;
		int         count;
		bit         open_seq;
		reordered_t typed_res;

		mismatch_count = 0;
		send_burst     = 0;
		hold_req       = 0;
		group_size_q   = '0;
		held_count     = 0;
		foreach (held_vals[i]) held_vals[i] = '0;

		arst_n                   <= 1'b0;
		cfg_bus.valid            <= 1'b0;
		cfg_bus.data             <= '0;
		item_bus.valid           <= 1'b0;
		item_bus.value           <= '0;
		item_bus.end_of_sequence <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Pass-through after reset, extremes of the value
		add_row(0, 0, 32'sh7FFFFFFF, 0, 1, 32'sh7FFFFFFF, 0);
		add_row(0, 0, 32'sh80000000, 1, 1, 32'sh80000000, 1);
		add_row(0, 0, -32'sd1,       0, 1, -32'sd1,       0);
		add_row(1, 1, 32'sd0,        1, 1, 32'sd0,        1);
		// Group of three, then a partial tail
		add_row(1, 3, 32'sd1, 0);
		add_row(0, 0, 32'sd2, 0);
		add_row(0, 0, 32'sd3, 0);
		add_row(0, 0, 32'sd4, 0);
		add_row(0, 0, 32'sd5, 1);
		// Oversized group size ending early
		add_row(1, 31, 32'sh12345678, 0);
		add_row(1, 31, -32'sh5A5A5A5B, 1);
		// Size lowered while values are held
		add_row(1, 4, 32'sd6, 0);
		add_row(0, 0, 32'sd7, 0);
		add_row(0, 0, 32'sd8, 0);
		add_row(1, 2, 32'sd9, 0);
		// Pass-through with values still held
		add_row(1, 5, 32'sd10, 0);
		add_row(0, 0, 32'sd11, 0);
		add_row(1, 0, 32'sd12, 0);
		// Group completes on the end-of-sequence item
		add_row(1, 2, 32'sd13, 0);
		add_row(0, 0, 32'sd14, 1);

		foreach (dir_rows[r]) begin
			if (dir_rows[r].set_size && (r == 0 || dir_rows[r].size != group_size_q))
				write_size(dir_rows[r].size);
			if (dir_rows[r].typed) begin
				offer(dir_rows[r].value, dir_rows[r].eos);
				fresh_results.delete();
				reorder_values(dir_rows[r].value, dir_rows[r].eos);
				typed_res.value_out     = dir_rows[r].exp_value;
				typed_res.last_of_run   = 1'b1;
				typed_res.sequence_done = dir_rows[r].exp_done;
				pending_results.push_back(typed_res);
			end else begin
				send_and_predict(dir_rows[r].value, dir_rows[r].eos);
			end
		end

		// Random phases, one group size each
		phase_sizes = '{16, 2, 31, 5, 0, 3, 1, 17, 8, 9, 4, 16};
		phase_sizes[9] = $urandom_range(2, 15);
		for (int p = 0; p < NUM_PHASES; p++) begin
			write_size(kgr_pkg::GS_W'(phase_sizes[p]));
			if (p == 1)
				hold_req = 1;
			send_burst = ($urandom_range(0, 3) == 0);
			if (phase_sizes[p] < 2)
				k_eff = 1;
			else if (phase_sizes[p] > MAX_GROUP)
				k_eff = MAX_GROUP;
			else
				k_eff = phase_sizes[p];
			count = 0;
			while (count < 5) begin
				seq_len  = $urandom_range(1, 2 * k_eff + 2);
				// now and then a sequence is left open, its values running on into the next sequence or across the next size change
				open_seq = ($urandom_range(0, 7) == 0);
				for (int j = 0; j < seq_len; j++) begin
					send_and_predict(pick_value(), (j == seq_len - 1) && !open_seq);
					count++;
				end
			end
		end

		// Drain
		item_bus.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (END_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

[files.f]
rtl/kgr_pkg.sv
rtl/kgr_if.sv
rtl/kgr_cell.sv
rtl/kgr_group_reverser_top.sv
rtl/k_group_reverser_top.sv
test/tb.sv
